// ----- sv/sprc_pkg.sv -----
package sprc_pkg;

  localparam int ROW_BYTES = 8;
  localparam int HDR_BYTES = 3;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HDR_BYTES + ROW_BYTES + 1);
  localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(HDR_BYTES + ROW_BYTES);
  localparam logic [POS_W-1:0] DATA_POS = POS_W'(HDR_BYTES);

  localparam logic [7:0] CMD_READ_SP = 8'hAA;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] ES_OFF_MASK = 8'h07;
  localparam logic [7:0] ES_PF = 8'h20;
  localparam logic [7:0] ES_AA = 8'h80;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IDLE    = 3'd1,
    ST_FLAGS   = 3'd2,
    ST_END_OFF = 3'd3,
    ST_ADDR    = 3'd4,
    ST_DATA    = 3'd5,
    ST_CRC     = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  ta1;
    logic [7:0]  ta2;
    logic [7:0]  es;
    logic [15:0] crc;
    logic        all_ones;
    logic        mismatch;
    logic [7:0]  crc_low;
  } acc_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] ta1;
    logic [7:0] ta2;
    logic [7:0] es;
  } result_t;

  // One byte of the 1-Wire CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_SEED = crc16_byte(16'h0000, CMD_READ_SP);

endpackage

// ----- sv/sprc_item_if.sv -----
interface sprc_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] response_byte;
  logic [7:0] expected_byte;
  logic [6:0] row_address;
  logic       verify_data;

  modport source (output valid, response_byte, expected_byte, row_address, verify_data,
                  input ready);
  modport sink (input valid, response_byte, expected_byte, row_address, verify_data,
                output ready);
endinterface

// ----- sv/sprc_result_if.sv -----
interface sprc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] check_status;
  logic [7:0] auth_ta1;
  logic [7:0] auth_ta2;
  logic [7:0] auth_es;

  modport source (output valid, check_status, auth_ta1, auth_ta2, auth_es, input ready);
  modport sink (input valid, check_status, auth_ta1, auth_ta2, auth_es, output ready);
endinterface

// ----- sv/sprc_accum.sv -----
module sprc_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [7:0]                 response_byte,
  input  logic [7:0]                 expected_byte,
  output logic                       last,
  output sprc_pkg::acc_t             acc
);

  logic [sprc_pkg::POS_W-1:0] pos;
  sprc_pkg::acc_t acc_next;

  assign last = (pos == sprc_pkg::LAST_POS);

  always_comb begin
    acc_next = acc;
    if (response_byte != sprc_pkg::IDLE_BYTE) begin
      acc_next.all_ones = 1'b0;
    end
    case (pos)
      sprc_pkg::POS_W'(0): acc_next.ta1 = response_byte;
      sprc_pkg::POS_W'(1): acc_next.ta2 = response_byte;
      sprc_pkg::POS_W'(2): acc_next.es = response_byte;
      default: begin
        if (pos >= sprc_pkg::DATA_POS && pos < sprc_pkg::CRC_LO_POS &&
            response_byte != expected_byte) begin
          acc_next.mismatch = 1'b1;
        end
      end
    endcase
    if (pos < sprc_pkg::CRC_LO_POS) begin
      acc_next.crc = sprc_pkg::crc16_byte(acc.crc, response_byte);
    end else if (pos == sprc_pkg::CRC_LO_POS) begin
      acc_next.crc_low = response_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      pos <= '0;
      acc.ta1 <= '0;
      acc.ta2 <= '0;
      acc.es <= '0;
      acc.crc <= sprc_pkg::CRC_SEED;
      acc.all_ones <= 1'b1;
      acc.mismatch <= 1'b0;
      acc.crc_low <= '0;
    end else if (take) begin
      pos <= pos + 1'b1;
      acc <= acc_next;
    end
  end

endmodule

// ----- sv/sprc_judge.sv -----
module sprc_judge (
  input  sprc_pkg::acc_t    acc,
  input  logic [7:0]        response_byte,
  input  logic [6:0]        row_address,
  input  logic              verify_data,
  output sprc_pkg::result_t res
);

  logic [2:0] t_off;
  logic [2:0] e_off;
  logic [2:0] want_end;
  logic [15:0] crc_inv;
  logic idle;
  logic crc_bad;

  assign t_off = acc.ta1[2:0];
  assign e_off = acc.es[2:0];
  assign want_end = 3'(row_address[2:0] + 3'(sprc_pkg::ROW_BYTES - 1));
  assign crc_inv = ~acc.crc;
  assign idle = acc.all_ones && (response_byte == sprc_pkg::IDLE_BYTE);
  assign crc_bad = (e_off < t_off) || (acc.crc_low != crc_inv[7:0]) ||
                   (response_byte != crc_inv[15:8]);

  always_comb begin
    res.ta1 = '0;
    res.ta2 = '0;
    res.es = '0;
    if (idle) begin
      res.status = sprc_pkg::ST_IDLE;
    end else if ((acc.es & (sprc_pkg::ES_PF | sprc_pkg::ES_AA)) != 8'h00) begin
      res.status = sprc_pkg::ST_FLAGS;
    end else if (e_off != want_end) begin
      res.status = sprc_pkg::ST_END_OFF;
    end else if (acc.ta2 != 8'h00 || acc.ta1 != {1'b0, row_address}) begin
      res.status = sprc_pkg::ST_ADDR;
    end else if (verify_data && acc.mismatch) begin
      res.status = sprc_pkg::ST_DATA;
    end else if (crc_bad) begin
      res.status = sprc_pkg::ST_CRC;
    end else begin
      res.status = sprc_pkg::ST_OK;
      res.ta1 = acc.ta1;
      res.ta2 = acc.ta2;
      res.es = acc.es;
    end
  end

endmodule

// ----- sv/scratchpad_response_checker.sv -----
// Checks a Read Scratchpad reply of a 1-Wire EEPROM after a one-row write. Feed the
// thirteen reply bytes (TA1, TA2, E/S, eight data bytes, CRC low, CRC high) one beat each,
// with the expected data byte, target row address and verify flag on every beat; the
// address and verify flag are used from the final beat. One result beat follows the CRC
// high byte in the next cycle, carrying the first failing check and, on success, the three
// copy authorization bytes. The block takes one reply byte every clock cycle: the
// byte-wide CRC-16 step fits in the accumulator's next-state logic, the header compares
// fit between the accumulator registers and the result register, and a waiting result
// does not stall input unless a second result is ready before the first is taken.
module scratchpad_response_checker (
  input logic          clk,
  input logic          rst,
  sprc_item_if.sink    item,
  sprc_result_if.source result
);

  logic take;
  logic last;
  sprc_pkg::acc_t acc;
  sprc_pkg::result_t judged;
  sprc_pkg::result_t res;
  logic res_valid;

  assign item.ready = !last || !res_valid || result.ready;
  assign take = item.valid && item.ready;

  sprc_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .response_byte (item.response_byte),
    .expected_byte (item.expected_byte),
    .last          (last),
    .acc           (acc)
  );

  sprc_judge u_judge (
    .acc           (acc),
    .response_byte (item.response_byte),
    .row_address   (item.row_address),
    .verify_data   (item.verify_data),
    .res           (judged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      res <= judged;
    end
  end

  assign result.valid = res_valid;
  assign result.check_status = res.status;
  assign result.auth_ta1 = res.ta1;
  assign result.auth_ta2 = res.ta2;
  assign result.auth_es = res.es;

endmodule

// ----- sv/sprc_checker.sv -----
module sprc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] check_status,
  input logic [7:0] auth_ta1,
  input logic [7:0] auth_ta2,
  input logic [7:0] auth_es
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(check_status) && $stable(auth_es))
    else $error("result beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status != sprc_pkg::ST_OK |->
      auth_ta1 == 8'h00 && auth_ta2 == 8'h00 && auth_es == 8'h00)
    else $error("authorization bytes given with a failing status");

  a_ok_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status == sprc_pkg::ST_OK |->
      auth_ta2 == 8'h00 && (auth_es & (sprc_pkg::ES_PF | sprc_pkg::ES_AA)) == 8'h00 &&
      auth_es[2:0] >= auth_ta1[2:0])
    else $error("ok status with an invalid header");

  a_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result beat without an accepted reply byte");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind scratchpad_response_checker sprc_checker u_sprc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .check_status (result.check_status),
  .auth_ta1     (result.auth_ta1),
  .auth_ta2     (result.auth_ta2),
  .auth_es      (result.auth_es)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import sprc_pkg::*;

  typedef logic [12:0][7:0] reply_t;

  typedef enum logic [1:0] {
    CRC_GOOD,
    CRC_BAD_LO,
    CRC_BAD_HI,
    CRC_ALL_ONES
  } crc_fill_t;

  typedef struct packed {
    logic [7:0] ta1;
    logic [7:0] ta2;
    logic [7:0] es;
    logic [7:0] fill;
    logic [7:0] step;
    logic       miss;
    crc_fill_t  crc_fill;
    logic [6:0] addr;
    logic       verify;
    logic       fixed;
    status_t    want;
    logic [7:0] want_ta1;
    logic [7:0] want_ta2;
    logic [7:0] want_es;
  } plan_row_t;

  typedef struct packed {
    logic    fixed;
    result_t res;
  } typed_result_t;

  localparam int PLAN_ROWS = 17;
  localparam int RANDOM_REPLIES = 110;

  logic clk;
  logic rst;

  sprc_item_if item_bus ();
  sprc_result_if result_bus ();

  scratchpad_response_checker dut (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus)
  );

  logic [3:0]  rx_pos;
  logic [15:0] rx_crc;
  logic [7:0]  rx_hdr [0:2];
  logic        rx_all_ff;
  logic        rx_diff;
  logic [7:0]  rx_crc_lo;

  result_t       pending_results [$];
  typed_result_t typed_results [$];
  result_t       due;
  int            failures = 0;
  int            results_checked = 0;
  logic          steady_tx = 1'b0;
  plan_row_t     plan [PLAN_ROWS];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = {1'b0, c[15:1]} ^ 16'hA001;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

  function automatic reply_t seal_crc(input reply_t r);
    logic [15:0] c;
    c = crc_step(16'h0000, CMD_READ_SP);
    for (int i = 0; i < 11; i++) begin
      c = crc_step(c, r[i]);
    end
    c = ~c;
    r[11] = c[7:0];
    r[12] = c[15:8];
    return r;
  endfunction

  task automatic clear_reply_state();
    rx_pos = '0;
    rx_crc = crc_step(16'h0000, CMD_READ_SP);
    rx_hdr[0] = '0;
    rx_hdr[1] = '0;
    rx_hdr[2] = '0;
    rx_all_ff = 1'b1;
    rx_diff = 1'b0;
    rx_crc_lo = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic [7:0] e, input logic [6:0] a,
                             input logic v);
    result_t       r;
    typed_result_t t;
    logic [15:0]   inv;
    logic [2:0]    end_want;
    status_t       st;
    if (b != IDLE_BYTE) begin
      rx_all_ff = 1'b0;
    end
    if (rx_pos < DATA_POS) begin
      rx_hdr[rx_pos[1:0]] = b;
    end else if (rx_pos < CRC_LO_POS && b != e) begin
      rx_diff = 1'b1;
    end
    if (rx_pos < CRC_LO_POS) begin
      rx_crc = crc_step(rx_crc, b);
    end else if (rx_pos == CRC_LO_POS) begin
      rx_crc_lo = b;
    end
    if (rx_pos < LAST_POS) begin
      rx_pos = rx_pos + 4'd1;
      return;
    end
    inv = ~rx_crc;
    end_want = a[2:0] + 3'd7;
    if (rx_all_ff) begin
      st = ST_IDLE;
    end else if ((rx_hdr[2] & (ES_PF | ES_AA)) != 8'h00) begin
      st = ST_FLAGS;
    end else if (rx_hdr[2][2:0] != end_want) begin
      st = ST_END_OFF;
    end else if (rx_hdr[1] != 8'h00 || rx_hdr[0] != {1'b0, a}) begin
      st = ST_ADDR;
    end else if (v && rx_diff) begin
      st = ST_DATA;
    end else if (rx_hdr[2][2:0] < rx_hdr[0][2:0] || rx_crc_lo != inv[7:0]
                 || b != inv[15:8]) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end
    r.status = st;
    r.ta1 = (st == ST_OK) ? rx_hdr[0] : 8'h00;
    r.ta2 = (st == ST_OK) ? rx_hdr[1] : 8'h00;
    r.es = (st == ST_OK) ? rx_hdr[2] : 8'h00;
    if (typed_results.size() != 0) begin
      t = typed_results.pop_front();
      if (t.fixed) begin
        r = t.res;
      end
    end
    pending_results.push_back(r);
    clear_reply_state();
  endtask

  always @(posedge clk) begin
    if (!rst && item_bus.valid && item_bus.ready) begin
      absorb_byte(item_bus.response_byte, item_bus.expected_byte, item_bus.row_address,
                  item_bus.verify_data);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      results_checked = results_checked + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: check_status %0d", result_bus.check_status);
        failures++;
      end else begin
        due = pending_results.pop_front();
        if (result_bus.check_status != due.status) begin
          $error("check_status: expected %0d, got %0d", due.status, result_bus.check_status);
          failures++;
        end
        if (result_bus.auth_ta1 != due.ta1) begin
          $error("auth_ta1: expected %h, got %h", due.ta1, result_bus.auth_ta1);
          failures++;
        end
        if (result_bus.auth_ta2 != due.ta2) begin
          $error("auth_ta2: expected %h, got %h", due.ta2, result_bus.auth_ta2);
          failures++;
        end
        if (result_bus.auth_es != due.es) begin
          $error("auth_es: expected %h, got %h", due.es, result_bus.auth_es);
          failures++;
        end
      end
    end
  end

  // The result side holds off once for a long stretch so that the input backs up.
  initial begin
    logic held_off;
    held_off = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_checked >= 30) begin
        held_off = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if (results_checked >= 60 && results_checked < 80) begin
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [7:0] e, input logic [6:0] a,
                           input logic v);
    if (!steady_tx) begin
      while ($urandom_range(99) < 33) begin
        item_bus.valid <= 1'b0;
        @(negedge clk);
      end
    end
    item_bus.valid <= 1'b1;
    item_bus.response_byte <= b;
    item_bus.expected_byte <= e;
    item_bus.row_address <= a;
    item_bus.verify_data <= v;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Address and verify flag only count on the final beat, so earlier beats carry inverted or random values.
  task automatic send_reply(input reply_t rsp, input reply_t xb, input logic [6:0] a,
                            input logic v, input logic directed);
    logic [6:0] a_early;
    logic       v_early;
    for (int i = 0; i < 13; i++) begin
      a_early = directed ? ~a : 7'($urandom_range(127));
      v_early = directed ? ~v : 1'($urandom_range(1));
      send_byte(rsp[i], xb[i], (i == 12) ? a : a_early, (i == 12) ? v : v_early);
    end
  endtask

  initial begin
    plan_row_t  row;
    reply_t     rsp;
    reply_t     xb;
    logic [6:0] addr;
    logic       verify;
    logic [7:0] es;
    int         pick;

    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.response_byte = '0;
    item_bus.expected_byte = '0;
    item_bus.row_address = '0;
    item_bus.verify_data = 1'b0;
    clear_reply_state();

    plan = '{
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, CRC_ALL_ONES, 7'h00, 1'b1, 1'b1,
        ST_IDLE, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 1'b0, CRC_GOOD, 7'h00, 1'b1, 1'b1,
        ST_OK, 8'h00, 8'h00, 8'h07},
      '{8'h78, 8'h00, 8'h5F, 8'hFF, 8'h00, 1'b0, CRC_GOOD, 7'h78, 1'b1, 1'b1,
        ST_OK, 8'h78, 8'h00, 8'h5F},
      '{8'h08, 8'h00, 8'h27, 8'h12, 8'h11, 1'b0, CRC_GOOD, 7'h08, 1'b1, 1'b1,
        ST_FLAGS, 8'h00, 8'h00, 8'h00},
      '{8'h10, 8'h00, 8'h87, 8'h34, 8'h0F, 1'b0, CRC_GOOD, 7'h10, 1'b1, 1'b1,
        ST_FLAGS, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h03, 8'h66, 8'h01, 1'b0, CRC_GOOD, 7'h00, 1'b1, 1'b1,
        ST_END_OFF, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h01, 8'h07, 8'h80, 8'h03, 1'b0, CRC_GOOD, 7'h00, 1'b1, 1'b1,
        ST_ADDR, 8'h00, 8'h00, 8'h00},
      '{8'h08, 8'h00, 8'h07, 8'hC3, 8'h05, 1'b0, CRC_GOOD, 7'h10, 1'b1, 1'b1,
        ST_ADDR, 8'h00, 8'h00, 8'h00},
      '{8'h20, 8'h00, 8'h07, 8'h5A, 8'h21, 1'b1, CRC_GOOD, 7'h20, 1'b1, 1'b1,
        ST_DATA, 8'h00, 8'h00, 8'h00},
      '{8'h20, 8'h00, 8'h07, 8'h5A, 8'h21, 1'b1, CRC_GOOD, 7'h20, 1'b0, 1'b1,
        ST_OK, 8'h20, 8'h00, 8'h07},
      '{8'h30, 8'h00, 8'h07, 8'hA5, 8'h3C, 1'b0, CRC_BAD_LO, 7'h30, 1'b1, 1'b1,
        ST_CRC, 8'h00, 8'h00, 8'h00},
      '{8'h30, 8'h00, 8'h07, 8'hA5, 8'h3C, 1'b0, CRC_BAD_HI, 7'h30, 1'b1, 1'b1,
        ST_CRC, 8'h00, 8'h00, 8'h00},
      '{8'h03, 8'h00, 8'h02, 8'h0E, 8'h77, 1'b0, CRC_GOOD, 7'h03, 1'b1, 1'b1,
        ST_CRC, 8'h00, 8'h00, 8'h00},
      '{8'h40, 8'h00, 8'h07, 8'h99, 8'h13, 1'b1, CRC_BAD_LO, 7'h40, 1'b0, 1'b1,
        ST_CRC, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, CRC_GOOD, 7'h00, 1'b1, 1'b1,
        ST_FLAGS, 8'h00, 8'h00, 8'h00},
      '{8'h48, 8'h00, 8'h1F, 8'h9C, 8'h47, 1'b0, CRC_GOOD, 7'h48, 1'b0, 1'b0,
        ST_OK, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h00, 8'h47, 8'h2B, 8'hE1, 1'b1, CRC_GOOD, 7'h50, 1'b1, 1'b0,
        ST_OK, 8'h00, 8'h00, 8'h00}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      row = plan[n];
      rsp[0] = row.ta1;
      rsp[1] = row.ta2;
      rsp[2] = row.es;
      for (int i = 0; i < ROW_BYTES; i++) begin
        rsp[3 + i] = row.fill + 8'(i) * row.step;
      end
      rsp = seal_crc(rsp);
      case (row.crc_fill)
        CRC_BAD_LO: begin
          rsp[11] = rsp[11] ^ 8'h01;
        end
        CRC_BAD_HI: begin
          rsp[12] = rsp[12] ^ 8'h80;
        end
        CRC_ALL_ONES: begin
          rsp[11] = IDLE_BYTE;
          rsp[12] = IDLE_BYTE;
        end
        default: begin
        end
      endcase
      for (int i = 0; i < 13; i++) begin
        xb[i] = (i >= 3 && i < 11) ? rsp[i] : ~rsp[i];
      end
      if (row.miss) begin
        xb[5] = xb[5] ^ 8'h10;
      end
      typed_results.push_back('{row.fixed,
                                '{row.want, row.want_ta1, row.want_ta2, row.want_es}});
      send_reply(rsp, xb, row.addr, row.verify, 1'b1);
    end

    for (int k = 0; k < RANDOM_REPLIES; k++) begin
      steady_tx = (k >= 50 && k < 70);
      if (k == 90) begin
        item_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(99);
      addr = 7'($urandom_range(127));
      verify = 1'($urandom_range(1));
      for (int i = 0; i < 13; i++) begin
        xb[i] = 8'($urandom_range(255));
        rsp[i] = 8'($urandom_range(255));
      end
      if (pick < 4) begin
        rsp = '1;
      end else if (pick >= 14) begin
        if ($urandom_range(9) != 0) begin
          addr[2:0] = 3'd0;
        end
        if ($urandom_range(19) != 0) begin
          rsp[0] = {1'b0, addr};
        end
        if ($urandom_range(19) != 0) begin
          rsp[1] = 8'h00;
        end
        es = 8'($urandom_range(255)) & ~(ES_PF | ES_AA | ES_OFF_MASK);
        es[2:0] = addr[2:0] + 3'd7;
        if ($urandom_range(19) == 0) begin
          es = es | ES_PF;
        end
        if ($urandom_range(19) == 0) begin
          es = es | ES_AA;
        end
        if ($urandom_range(12) == 0) begin
          es[2:0] = 3'($urandom_range(7));
        end
        rsp[2] = es;
        rsp = seal_crc(rsp);
        if ($urandom_range(9) == 0) begin
          rsp[11 + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
        end
        for (int i = 3; i < 11; i++) begin
          if ($urandom_range(39) != 0) begin
            xb[i] = rsp[i];
          end
        end
      end
      send_reply(rsp, xb, addr, verify, 1'b0);
    end

    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
